/* design/xrg_pkg.sv */
// Shared types, constants and the xorshift step function for the xorshift32 range generator.
// Used by every module of the block; it depends on nothing else.
package xrg_pkg;

	localparam logic [31:0] DEFAULT_SEED = 32'h1234_5678;
	localparam int SHIFT_A = 13;
	localparam int SHIFT_B = 17;
	localparam int SHIFT_C = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [32:0] WORD_MAX = 33'h0_FFFF_FFFF;
	localparam logic [32:0] WORD_MAX_X2 = 33'h1_FFFF_FFFE;

	typedef enum logic [1:0] {
		ACT_RESEED = 2'd0,
		ACT_INT    = 2'd1,
		ACT_UNIT   = 2'd2,
		ACT_SCALED = 2'd3
	} xrg_act_t;

	typedef struct packed {
		xrg_act_t           action;
		logic        [31:0] seed_value;
		logic signed [31:0] low_bound;
		logic signed [31:0] high_bound;
	} xrg_req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic        [31:0] random_word;
	} xrg_rsp_t;

	typedef struct packed {
		xrg_act_t    action;
		logic [31:0] word;
		logic [31:0] base;
		logic [31:0] mag;
		logic        neg;
	} xrg_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} xrg_qstat_t;

	function automatic logic [31:0] xrg_next(input logic [31:0] s);
		logic [31:0] t;
		t = s ^ (s << SHIFT_A);
		t = t ^ (t >> SHIFT_B);
		t = t ^ (t << SHIFT_C);
		return t;
	endfunction

endpackage

/* design/xrg_front.sv */
// Front part: accepts requests, holds the generator state and prepares bounds for the back part.
// Depends on xrg_pkg.
module xrg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  xrg_pkg::xrg_req_t   req_item,
	input  xrg_pkg::xrg_qstat_t q_stat,
	output logic                push,
	output xrg_pkg::xrg_entry_t push_entry
);
	import xrg_pkg::*;

	logic [31:0] gen_state_q;
	logic [31:0] word_c;
	logic [32:0] d_hl;
	logic [32:0] d_lh;
	logic        swap;
	logic        accept;

	assign req_stall = q_stat.full;
	assign accept = req_valid && !req_stall;
	assign push = accept && (req_item.action != ACT_RESEED);

	assign word_c = xrg_next(gen_state_q);
	assign d_hl = {req_item.high_bound[31], req_item.high_bound}
		- {req_item.low_bound[31], req_item.low_bound};
	assign d_lh = {req_item.low_bound[31], req_item.low_bound}
		- {req_item.high_bound[31], req_item.high_bound};
	assign swap = d_hl[32];

	always_comb begin
		push_entry.action = req_item.action;
		push_entry.word = word_c;
		push_entry.mag = swap ? d_lh[31:0] : d_hl[31:0];
		push_entry.neg = swap;
		if (req_item.action == ACT_INT && swap) begin
			push_entry.base = req_item.high_bound;
		end else begin
			push_entry.base = req_item.low_bound;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_state_q <= DEFAULT_SEED;
		end else if (accept) begin
			if (req_item.action == ACT_RESEED) begin
				gen_state_q <= (req_item.seed_value != 32'd0) ? req_item.seed_value
					: DEFAULT_SEED;
			end else begin
				gen_state_q <= word_c;
			end
		end
	end

	a_state_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		gen_state_q != 32'd0)
		else $error("Generator state has reached zero.");

	a_zero_seed: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_item.action == ACT_RESEED && req_item.seed_value == 32'd0
		|=> gen_state_q == DEFAULT_SEED)
		else $error("A zero seed did not load the default seed.");

endmodule

/* design/xrg_queue.sv */
// Short first-in first-out queue of prepared transactions between the front and back parts.
// Depends on xrg_pkg.
module xrg_queue #(
	parameter int DEPTH = xrg_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  xrg_pkg::xrg_entry_t push_entry,
	input  logic                pop,
	output xrg_pkg::xrg_entry_t pop_entry,
	output xrg_pkg::xrg_qstat_t q_stat
);
	import xrg_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	xrg_entry_t     slots_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign q_stat.full = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Queue holds more transactions than its depth.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("Queue popped while empty.");

endmodule

/* design/xrg_back.sv */
// Back part: remainder loop, scaling multiply and result register of the range generator.
// Depends on xrg_pkg.
module xrg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  xrg_pkg::xrg_qstat_t q_stat,
	input  xrg_pkg::xrg_entry_t pop_entry,
	output logic                pop,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output xrg_pkg::xrg_rsp_t   rsp_item
);
	import xrg_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_MUL,
		B_FOLD,
		B_OUT
	} bstate_t;

	bstate_t     state_q;
	xrg_act_t    act_q;
	logic [31:0] word_q;
	logic [31:0] dvd_q;
	logic [31:0] base_q;
	logic [31:0] mag_q;
	logic        neg_q;
	logic [32:0] span_q;
	logic [32:0] rem_q;
	logic [4:0]  cnt_q;
	logic [63:0] prod_q;
	logic [31:0] quo_q;
	logic        rsp_valid_q;
	xrg_rsp_t    rsp_item_q;

	logic [33:0] trial_c;
	logic [32:0] fold_c;
	logic [1:0]  corr_c;
	logic [31:0] result_c;
	logic        out_free;

	assign pop = (state_q == B_IDLE) && !q_stat.empty;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item = rsp_item_q;

	assign trial_c = {rem_q, dvd_q[31]} - {1'b0, span_q};
	assign fold_c = {1'b0, prod_q[63:32]} + {1'b0, prod_q[31:0]};

	always_comb begin
		if (fold_c >= WORD_MAX_X2) begin
			corr_c = 2'd2;
		end else if (fold_c >= WORD_MAX) begin
			corr_c = 2'd1;
		end else begin
			corr_c = 2'd0;
		end
	end

	always_comb begin
		case (act_q)
			ACT_INT: begin
				result_c = base_q + rem_q[31:0];
			end
			ACT_SCALED: begin
				result_c = neg_q ? (base_q - quo_q) : (base_q + quo_q);
			end
			default: begin
				result_c = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			rsp_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != B_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						act_q <= pop_entry.action;
						word_q <= pop_entry.word;
						dvd_q <= pop_entry.word;
						base_q <= pop_entry.base;
						mag_q <= pop_entry.mag;
						neg_q <= pop_entry.neg;
						span_q <= {1'b0, pop_entry.mag} + 33'd1;
						rem_q <= '0;
						cnt_q <= '1;
						case (pop_entry.action)
							ACT_INT: state_q <= B_DIV;
							ACT_SCALED: state_q <= B_MUL;
							default: state_q <= B_OUT;
						endcase
					end
				end
				B_DIV: begin
					if (!trial_c[33]) begin
						rem_q <= trial_c[32:0];
					end else begin
						rem_q <= {rem_q[31:0], dvd_q[31]};
					end
					dvd_q <= {dvd_q[30:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= B_OUT;
					end
				end
				B_MUL: begin
					prod_q <= 64'(mag_q) * 64'(word_q);
					state_q <= B_FOLD;
				end
				B_FOLD: begin
					quo_q <= prod_q[63:32] + 32'(corr_c);
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (out_free) begin
						rsp_item_q.result_value <= result_c;
						rsp_item_q.random_word <= word_q;
						rsp_valid_q <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> rem_q < span_q)
		else $error("Partial remainder is not below the span.");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_OUT && rsp_valid_q && rsp_stall |=> state_q == B_OUT)
		else $error("Result left the back part while the output was stalled.");

endmodule

/* design/xorshift32_range_generator.sv */
// Top level of the xorshift32 range generator: front part, transaction queue and back part.
// Depends on xrg_pkg, xrg_front, xrg_queue and xrg_back.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | req_item (action, seed, bounds)
//  rsp     | out       | rsp_valid, rsp_stall | rsp_item (result value, random word)
//
// A reseed is handled in the front part alone and gives no result.
// An integer transaction is offered after the one-bit-per-cycle remainder loop in the back part;
// a scaled one passes through the multiply and fold states, and a unit one goes straight to
// the output state.
// The front part keeps accepting while the queue has room, so stalls on either side
// are absorbed by the queue and the result register.
// Reset loads the generator with its default seed and empties the queue.
module xorshift32_range_generator #(
	parameter int QUEUE_DEPTH = xrg_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  xrg_pkg::xrg_req_t req_item,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output xrg_pkg::xrg_rsp_t rsp_item
);
	import xrg_pkg::*;

	xrg_qstat_t q_stat;
	xrg_entry_t push_entry;
	xrg_entry_t pop_entry;
	logic       push;
	logic       pop;

	xrg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_item   (req_item),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	xrg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.q_stat     (q_stat)
	);

	xrg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_entry (pop_entry),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

endmodule
